// ----- hw/rtl/dstm_pkg.sv -----
// ---------------------------------------------------------------------------
// dstm_pkg
// Shared constants, types and step functions of the seek time pipeline.
// ---------------------------------------------------------------------------
package dstm_pkg;

  localparam int FRAC      = 16;
  localparam int SEEK_W    = 20;
  localparam int CYL_W     = 16;
  localparam int TIME_W    = 18;
  localparam int DELTA_W   = 17;
  localparam int CFG_IDX_W = 3;

  localparam logic [SEEK_W-1:0] SEEK_MAX = '1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CYL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SINGLE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AVERAGE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FULL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SWITCH  = 3'd6;

  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_CONST = 2'd1;
  localparam logic [1:0] MODE_CURVE = 2'd2;
  localparam logic [1:0] MODE_LINE  = 2'd3;

  // Restoring divider: DIV_PER quotient bits per stage.
  localparam int DIV_W   = 64;
  localparam int DEN_W   = 18;
  localparam int DIV_PER = 4;
  localparam int DIV_ST  = DIV_W / DIV_PER;

  // Digit-by-digit square root: SQ_PER root bits per stage.
  localparam int SQ_IN_W  = 48;
  localparam int ROOT_W   = SQ_IN_W / 2;
  localparam int SQ_REM_W = ROOT_W + 2;
  localparam int SQ_PER   = 2;
  localparam int SQ_ST    = ROOT_W / SQ_PER;

  // Divide by three: floor(x / 3) = (x * RCP3) >> RCP3_SH for any x below
  // 2^47, built from four R3_W by R3_W partial products.
  localparam int                R3_W    = 23;
  localparam int                RCP3_SH = 47;
  localparam logic [2*R3_W-1:0] RCP3    = 46'h2AAA_AAAA_AAAB;
  localparam int                DIV3_ST = 2;

  // Pipeline stage positions.
  localparam int ST_IN   = 0;
  localparam int ST_PREP = ST_IN + 1;
  localparam int ST_MUL  = ST_PREP + 1;
  localparam int ST_ABS  = ST_MUL + 1;
  localparam int ST_DA0  = ST_ABS + 1;
  localparam int ST_SQ0  = ST_DA0 + DIV_ST;
  localparam int ST_M2   = ST_SQ0 + SQ_ST;
  localparam int ST_DB0  = ST_M2 + 1;
  localparam int ST_F1   = ST_DB0 + DIV3_ST;
  localparam int ST_F2   = ST_F1 + 1;
  localparam int ST_OUT  = ST_F2 + 1;
  localparam int N_ST    = ST_OUT + 1;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [DIV_W-1:0] work;
    logic [DEN_W-1:0] den;
  } div_work_t;

  typedef struct packed {
    logic [SQ_IN_W-1:0]  x;
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
  } sq_work_t;

  // The dividend shifts out at the top while quotient bits enter at the bottom.
  function automatic div_work_t div_steps(div_work_t x);
    div_work_t      w;
    logic [DEN_W:0] r;
    w = x;
    for (int k = 0; k < DIV_PER; k++) begin
      r = {w.rem, w.work[DIV_W-1]};
      w.work = {w.work[DIV_W-2:0], 1'b0};
      if (r >= {1'b0, w.den}) begin
        r = r - {1'b0, w.den};
        w.work[0] = 1'b1;
      end
      w.rem = r[DEN_W-1:0];
    end
    return w;
  endfunction

  function automatic sq_work_t sq_steps(sq_work_t x);
    sq_work_t              w;
    logic [SQ_REM_W+1:0]   r;
    logic [SQ_REM_W+1:0]   t;
    w = x;
    for (int k = 0; k < SQ_PER; k++) begin
      r = {w.rem, w.x[SQ_IN_W-1 -: 2]};
      w.x = {w.x[SQ_IN_W-3:0], 2'b00};
      t = (SQ_REM_W+2)'({w.root, 2'b01});
      if (r >= t) begin
        r = r - t;
        w.root = {w.root[ROOT_W-2:0], 1'b1};
      end else begin
        w.root = {w.root[ROOT_W-2:0], 1'b0};
      end
      w.rem = r[SQ_REM_W-1:0];
    end
    return w;
  endfunction

endpackage

// ----- hw/rtl/dstm_div.sv -----
// ---------------------------------------------------------------------------
// dstm_div
// Pipelined unsigned restoring divider, one enable per stage.
// ---------------------------------------------------------------------------
module dstm_div (
  input  logic                          clk,
  input  logic [dstm_pkg::DIV_ST-1:0]   en,
  input  logic [dstm_pkg::DIV_W-1:0]    num,
  input  logic [dstm_pkg::DEN_W-1:0]    den,
  output logic [dstm_pkg::DIV_W-1:0]    quo
);
  import dstm_pkg::*;

  div_work_t st     [0:DIV_ST-1];
  div_work_t st_next[0:DIV_ST-1];

  always_comb begin
    div_work_t first;
    first.rem  = '0;
    first.work = num;
    first.den  = den;
    st_next[0] = div_steps(first);
    for (int j = 1; j < DIV_ST; j++) begin
      st_next[j] = div_steps(st[j-1]);
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DIV_ST; j++) begin
      if (en[j]) begin
        st[j] <= st_next[j];
      end
    end
  end

  assign quo = st[DIV_ST-1].work;

endmodule

// ----- hw/rtl/disk_seek_time_model_top.sv -----
// ---------------------------------------------------------------------------
// disk_seek_time_model_top
// Disk arm seek time in microseconds from a cylinder distance and flags.
// ---------------------------------------------------------------------------
// Requests enter on the s_axis channel: the signed cylinder distance in
// tdata, the head-change and write flags in tuser. Each request yields one
// seek time on the m_axis channel, in request order.
// The registers are set through cfg_we/cfg_idx/cfg_data while no request is
// in flight, a rule for the user that the block does not enforce; a write
// takes effect for requests accepted from the next cycle. The datapath is a
// 38-stage pipeline: four front stages with a multiplier and an absolute
// value, two 16-stage restoring dividers running side by side, a 12-stage
// square root, a second multiplier, a two-stage divide by three through a
// reciprocal multiply and three stages of summing and rounding. One request
// is taken every cycle while no stall holds the input back. When the
// receiver stalls, items pile up into empty stages, so requests are still
// taken until the pipeline is full; nothing is dropped or repeated.
// Reset empties the pipeline and loads the register reset values.
// ---------------------------------------------------------------------------
module disk_seek_time_model_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [dstm_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [dstm_pkg::TIME_W-1:0]      cfg_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [23:0]                      s_axis_tdata,  // [16:0] cylinder_delta
  input  logic [1:0]                       s_axis_tuser,  // [0] head_change, [1] is_write
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [23:0]                      m_axis_tdata   // [19:0] seek_us
);
  import dstm_pkg::*;

  localparam int SK_W = 58;
  localparam int QB_W = 57;
  localparam int NA_W = 24;
  localparam int MY_W = 19;
  localparam int PR_W = 43;
  localparam int P2_W = 49;
  localparam int HI_W = SK_W - FRAC;

  typedef enum logic [2:0] {
    K_NONE, K_CONST, K_ZERO, K_SINGLE, K_LINE1, K_LINE2, K_CURVE
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic             hsw;
    logic             wr;
    logic             dpos;
    logic             sgn_b;
    logic             sgn_t;
    logic [CYL_W-1:0] e;
  } ctx_t;

  // Configuration and values derived from it.
  logic [1:0]             mode;
  logic [CYL_W-1:0]       cyl;
  logic [TIME_W-1:0]      single_t, average_t, full_t, settle_t, switch_t;
  logic [CYL_W-1:0]       ceff;
  logic [DEN_W-1:0]       c2, c3;
  logic signed [NA_W-1:0] na, nb;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_NONE;
      cyl       <= CYL_W'(1);
      single_t  <= '0;
      average_t <= '0;
      full_t    <= '0;
      settle_t  <= '0;
      switch_t  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MODE:    mode      <= cfg_data[1:0];
        REG_CYL:     cyl       <= cfg_data[CYL_W-1:0];
        REG_SINGLE:  single_t  <= cfg_data;
        REG_AVERAGE: average_t <= cfg_data;
        REG_FULL:    full_t    <= cfg_data;
        REG_SETTLE:  settle_t  <= cfg_data;
        REG_SWITCH:  switch_t  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Curve coefficients are rebuilt each cycle; requests first use them in the
  // stage after the input register, so a write reaches requests accepted after it.
  always_ff @(posedge clk) begin
    ceff <= (cyl == '0) ? CYL_W'(1) : cyl;
    c2   <= DEN_W'({ceff, 1'b0});
    c3   <= DEN_W'({ceff, 1'b0}) + DEN_W'(ceff);
    na   <= (NA_W'(average_t) << 4) - NA_W'(average_t) - (NA_W'(single_t) << 3)
          - (NA_W'(single_t) << 1) - (NA_W'(full_t) << 2) - NA_W'(full_t);
    nb   <= (NA_W'(single_t) << 3) - NA_W'(single_t) - (NA_W'(average_t) << 4)
          + NA_W'(average_t) + (NA_W'(full_t) << 3);
  end

  // Stage valid bits and per-stage advance.
  logic [N_ST-1:0] vld;
  logic [N_ST-1:0] en;

  always_comb begin
    en[N_ST-1] = ~vld[N_ST-1] | m_axis_tready;
    for (int i = N_ST-2; i >= 0; i--) begin
      en[i] = ~vld[i] | en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < N_ST; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign s_axis_tready = en[0];

  // Flags that travel with every item.
  ctx_t ctx     [0:ST_OUT-1];
  ctx_t ctx_next[0:ST_OUT-1];

  logic [DELTA_W-1:0]     d0;
  logic [CYL_W-1:0]       e_p;
  logic [MY_W-1:0]        d3;
  logic                   near;
  kind_t                  kind_p;
  logic signed [NA_W-1:0] mx, mx_next;
  logic signed [MY_W-1:0] my, my_next;
  logic signed [PR_W-1:0] prod;
  logic [PR_W-1:0]        pmag;
  logic [DIV_W-1:0]       numb;
  logic [DEN_W-1:0]       denb, denb_next;
  logic signed [P2_W-1:0] p2;

  always_comb begin
    e_p  = CYL_W'(d0 - DELTA_W'(1));
    d3   = MY_W'({d0, 1'b0}) + MY_W'(d0);
    near = d3 <= MY_W'(ceff);
    case (mode)
      MODE_NONE:  kind_p = K_NONE;
      MODE_CONST: kind_p = K_CONST;
      MODE_CURVE: kind_p = (d0 == '0) ? K_ZERO : K_CURVE;
      default: begin
        if (d0 == '0) begin
          kind_p = K_ZERO;
        end else if (d0 == DELTA_W'(1)) begin
          kind_p = K_SINGLE;
        end else if (near) begin
          kind_p = K_LINE1;
        end else begin
          kind_p = K_LINE2;
        end
      end
    endcase
    case (kind_p)
      K_CURVE: begin
        mx_next = nb;
        my_next = $signed(MY_W'(e_p));
      end
      K_LINE1: begin
        mx_next = $signed(NA_W'(average_t)) - $signed(NA_W'(single_t));
        my_next = $signed(MY_W'({e_p, 1'b0}) + MY_W'(e_p));
      end
      K_LINE2: begin
        mx_next = $signed(NA_W'(full_t)) - $signed(NA_W'(average_t));
        my_next = $signed(d3 - MY_W'(ceff));
      end
      default: begin
        mx_next = '0;
        my_next = '0;
      end
    endcase
    case (ctx[ST_MUL].kind)
      K_CURVE: denb_next = c3;
      K_LINE1: denb_next = DEN_W'(ceff);
      default: denb_next = c2;
    endcase
    pmag = prod[PR_W-1] ? PR_W'(-prod) : PR_W'(prod);
  end

  always_comb begin
    for (int i = 1; i < ST_OUT; i++) begin
      ctx_next[i] = ctx[i-1];
    end
    ctx_next[ST_IN].kind  = K_NONE;
    ctx_next[ST_IN].hsw   = s_axis_tuser[0];
    ctx_next[ST_IN].wr    = s_axis_tuser[1];
    ctx_next[ST_IN].dpos  = 1'b0;
    ctx_next[ST_IN].sgn_b = 1'b0;
    ctx_next[ST_IN].sgn_t = 1'b0;
    ctx_next[ST_IN].e     = '0;
    ctx_next[ST_PREP].kind = kind_p;
    ctx_next[ST_PREP].dpos = d0 != '0;
    ctx_next[ST_PREP].e    = e_p;
    ctx_next[ST_ABS].sgn_b = prod[PR_W-1];
    ctx_next[ST_DB0].sgn_t = p2[P2_W-1];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ST_OUT; i++) begin
      if (en[i]) begin
        ctx[i] <= ctx_next[i];
      end
    end
    if (en[ST_IN]) begin
      if (s_axis_tdata[DELTA_W-1]) begin
        d0 <= DELTA_W'(-s_axis_tdata[DELTA_W-1:0]);
      end else begin
        d0 <= s_axis_tdata[DELTA_W-1:0];
      end
    end
    if (en[ST_PREP]) begin
      mx <= mx_next;
      my <= my_next;
    end
    if (en[ST_MUL]) begin
      prod <= PR_W'(mx) * PR_W'(my);
    end
    if (en[ST_ABS]) begin
      numb <= DIV_W'(pmag) << FRAC;
      denb <= denb_next;
    end
  end

  // Two dividers side by side: e / C for the root, and the linear term.
  logic [DIV_W-1:0]  quo_a, quo_b, quo_c;
  logic [2*R3_W-1:0] num_c;

  dstm_div u_div_root (
    .clk (clk),
    .en  (en[ST_DA0 +: DIV_ST]),
    .num (DIV_W'(ctx[ST_ABS].e) << (2 * FRAC)),
    .den (DEN_W'(ceff)),
    .quo (quo_a)
  );

  dstm_div u_div_lin (
    .clk (clk),
    .en  (en[ST_DA0 +: DIV_ST]),
    .num (numb),
    .den (denb),
    .quo (quo_b)
  );

  // Square root of the first quotient, with the linear term riding along.
  sq_work_t               sq [ST_SQ0:ST_M2-1];
  logic signed [QB_W-1:0] qb [ST_SQ0:ST_F1-1];
  logic signed [QB_W-1:0] qb_first;
  sq_work_t               sq_first;

  always_comb begin
    sq_first.x    = quo_a[SQ_IN_W-1:0];
    sq_first.rem  = '0;
    sq_first.root = '0;
    qb_first = ctx[ST_SQ0-1].sgn_b ? -$signed(QB_W'(quo_b[QB_W-2:0]))
                                   :  $signed(QB_W'(quo_b[QB_W-2:0]));
  end

  always_ff @(posedge clk) begin
    if (en[ST_SQ0]) begin
      sq[ST_SQ0] <= sq_steps(sq_first);
      qb[ST_SQ0] <= qb_first;
    end
    for (int i = ST_SQ0 + 1; i < ST_M2; i++) begin
      if (en[i]) begin
        sq[i] <= sq_steps(sq[i-1]);
      end
    end
    for (int i = ST_SQ0 + 1; i < ST_F1; i++) begin
      if (en[i]) begin
        qb[i] <= qb[i-1];
      end
    end
    if (en[ST_M2]) begin
      p2 <= P2_W'(na) * $signed(P2_W'(sq[ST_M2-1].root));
    end
  end

  // The magnitude of the root term stays below 2^46, so the reciprocal
  // multiply gives the exact quotient by three.
  logic [2*R3_W-1:0] pp_hh, pp_hl, pp_lh, pp_ll;
  logic [4*R3_W-1:0] sum3;

  assign num_c = p2[P2_W-1] ? (2*R3_W)'($unsigned(-p2)) : (2*R3_W)'($unsigned(p2));
  assign sum3  = {pp_hh, {(2*R3_W){1'b0}}} + ((4*R3_W)'(pp_hl) << R3_W)
               + ((4*R3_W)'(pp_lh) << R3_W) + (4*R3_W)'(pp_ll);

  always_ff @(posedge clk) begin
    if (en[ST_DB0]) begin
      pp_hh <= num_c[2*R3_W-1:R3_W] * RCP3[2*R3_W-1:R3_W];
      pp_hl <= num_c[2*R3_W-1:R3_W] * RCP3[R3_W-1:0];
      pp_lh <= num_c[R3_W-1:0] * RCP3[2*R3_W-1:R3_W];
      pp_ll <= num_c[R3_W-1:0] * RCP3[R3_W-1:0];
    end
    if (en[ST_DB0+1]) begin
      quo_c <= DIV_W'(sum3[4*R3_W-1:RCP3_SH]);
    end
  end

  // Sum, settle, head-switch floor and rounding.
  logic signed [SK_W-1:0] seek1, seek2;
  logic signed [SK_W-1:0] base, qv, tv, settle_add, sw_q, rnd;
  logic [HI_W-1:0]        hi;
  logic [SEEK_W-1:0]      res, res_next;
  localparam logic signed [SK_W-1:0] HALF = SK_W'(1) <<< (FRAC - 1);

  always_comb begin
    case (ctx[ST_F1-1].kind)
      K_CURVE, K_LINE1, K_SINGLE: base = $signed(SK_W'(single_t) << FRAC);
      K_LINE2:                    base = $signed(SK_W'(average_t) << FRAC);
      default:                    base = '0;
    endcase
    case (ctx[ST_F1-1].kind)
      K_CURVE, K_LINE1, K_LINE2: qv = SK_W'(qb[ST_F1-1]);
      default:                   qv = '0;
    endcase
    tv = '0;
    if (ctx[ST_F1-1].kind == K_CURVE) begin
      tv = ctx[ST_F1-1].sgn_t ? -$signed(SK_W'(quo_c[P2_W-3:0]))
                              :  $signed(SK_W'(quo_c[P2_W-3:0]));
    end
    settle_add = '0;
    if (ctx[ST_F2-1].wr && (ctx[ST_F2-1].dpos || ctx[ST_F2-1].hsw)) begin
      settle_add = $signed(SK_W'(settle_t) << FRAC);
    end
    sw_q = $signed(SK_W'(switch_t) << FRAC);
    rnd  = seek2 + HALF;
    hi   = rnd[SK_W-1:FRAC];
    case (ctx[ST_OUT-1].kind)
      K_NONE:  res_next = '0;
      K_CONST: res_next = SEEK_W'(average_t);
      default: begin
        // The floor value is a whole number of microseconds already.
        if (ctx[ST_OUT-1].hsw && (seek2 < sw_q)) begin
          res_next = SEEK_W'(switch_t);
        end else if (seek2 <= 0) begin
          res_next = '0;
        end else if (|hi[HI_W-1:SEEK_W]) begin
          res_next = SEEK_MAX;
        end else begin
          res_next = hi[SEEK_W-1:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[ST_F1]) begin
      seek1 <= base + qv + tv;
    end
    if (en[ST_F2]) begin
      seek2 <= seek1 + settle_add;
    end
    if (en[ST_OUT]) begin
      res <= res_next;
    end
  end

  assign m_axis_tvalid = vld[ST_OUT];
  assign m_axis_tdata  = {(24 - SEEK_W)'(0), res};

  // An empty or draining output stage lets every stage advance.
  a_ready_when_drain: assert property (@(posedge clk) disable iff (rst)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled although the output stage was free");

  // An accepted transaction occupies the first stage on the next cycle.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> vld[ST_IN])
    else $error("accepted transaction did not enter the pipeline");

  // An item ahead of the output register moves into it when allowed.
  a_last_step: assert property (@(posedge clk) disable iff (rst)
    (vld[ST_F2] && en[ST_OUT]) |=> m_axis_tvalid)
    else $error("item lost before the output register");

endmodule

// ----- tb/sv/disk_seek_time_model_top_test.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// disk_seek_time_model_top_test
// Self-checking bench for the disk seek time pipeline: seek requests are
// streamed in under several register settings and idle patterns, and every
// returned seek time is compared with a fixed-point prediction.
// ---------------------------------------------------------------------------
module disk_seek_time_model_top_test;
  import dstm_pkg::*;

  localparam int  LATENCY = 37;
  localparam longint CYCLE_LIMIT = 600000;

  typedef struct {
    logic signed [DELTA_W-1:0] delta;
    logic                      head_change;
    logic                      is_write;
  } seek_req_t;

  // Scoreboard: keeps its own copy of the registers and a queue of seek times.
  class seek_scoreboard;
    logic [1:0]         mode;
    logic [CYL_W-1:0]   cyl;
    logic [TIME_W-1:0]  single_t, avg_t, full_t, settle_t, switch_t;
    logic [SEEK_W-1:0]  expected_seek[$];
    int                 errors;
    int                 checked;

    function new();
      mode = MODE_NONE; cyl = 1; single_t = 0; avg_t = 0; full_t = 0;
      settle_t = 0; switch_t = 0; errors = 0; checked = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] val);
      case (idx)
        REG_MODE:    mode = val[1:0];
        REG_CYL:     cyl = val[CYL_W-1:0];
        REG_SINGLE:  single_t = val;
        REG_AVERAGE: avg_t = val;
        REG_FULL:    full_t = val;
        REG_SETTLE:  settle_t = val;
        REG_SWITCH:  switch_t = val;
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (x >= root + bitv) begin
          x = x - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return root;
    endfunction

    function logic [SEEK_W-1:0] predict_seek(seek_req_t r);
      longint one, d, c, s, a, f, e, rt, t1, t2, seek;
      longint unsigned q;
      one = longint'(1) << FRAC;
      d = longint'(r.delta);
      if (d < 0) d = -d;
      c = (cyl == 0) ? 1 : longint'(cyl);
      s = longint'(single_t);
      a = longint'(avg_t);
      f = longint'(full_t);
      seek = 0;
      if (mode == MODE_NONE) return '0;
      if (mode == MODE_CONST) return SEEK_W'(avg_t);
      if (mode == MODE_CURVE) begin
        if (d > 0) begin
          e = d - 1;
          q = (longint'(e) << (2 * FRAC)) / longint'(c);
          rt = longint'(int_sqrt(q));
          t1 = ((-10 * s + 15 * a - 5 * f) * rt) / 3;
          t2 = ((7 * s - 15 * a + 8 * f) * e * one) / (3 * c);
          seek = t1 + t2 + s * one;
        end
      end else begin
        if (d == 1) seek = s * one;
        else if (d > 1 && d <= c / 3) seek = (3 * (d - 1) * (a - s) * one) / c + s * one;
        else if (d > 1) seek = ((3 * d - c) * (f - a) * one) / (2 * c) + a * one;
      end
      if (r.is_write && (d > 0 || r.head_change)) seek += longint'(settle_t) * one;
      if (r.head_change && seek < longint'(switch_t) * one) seek = longint'(switch_t) * one;
      if (seek <= 0) return '0;
      seek = (seek + (longint'(1) << (FRAC - 1))) >>> FRAC;
      if (seek > longint'(SEEK_MAX)) return SEEK_MAX;
      return SEEK_W'(seek);
    endfunction

    function void note_request(seek_req_t r);
      expected_seek.push_back(predict_seek(r));
    endfunction

    task report(string what);
      $display("MISMATCH: %s", what);
      errors++;
    endtask

    task check_result(logic [SEEK_W-1:0] got);
      logic [SEEK_W-1:0] want;
      if (expected_seek.size() == 0) begin
        report($sformatf("seek time %0d with no request outstanding", got));
      end else begin
        want = expected_seek.pop_front();
        checked++;
        if (got !== want)
          report($sformatf("result %0d: seek_us %0d, expected %0d", checked, got, want));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [TIME_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  seek_scoreboard sb = new();
  longint cycles = 0;
  int tx_gap_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold = 0;
  int sent = 0;

  disk_seek_time_model_top u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: a long hold-off counts down on its own; otherwise random stalls.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[SEEK_W-1:0]);
  end

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task set_all(logic [1:0] mode, logic [CYL_W-1:0] cyl, logic [TIME_W-1:0] s,
               logic [TIME_W-1:0] a, logic [TIME_W-1:0] f, logic [TIME_W-1:0] st,
               logic [TIME_W-1:0] sw);
    write_reg(REG_MODE, TIME_W'(mode));
    write_reg(REG_CYL, TIME_W'(cyl));
    write_reg(REG_SINGLE, s);
    write_reg(REG_AVERAGE, a);
    write_reg(REG_FULL, f);
    write_reg(REG_SETTLE, st);
    write_reg(REG_SWITCH, sw);
  endtask

  // Called and returns right after a negedge, once the request is accepted.
  task send_request(logic signed [DELTA_W-1:0] delta, logic hc, logic wr);
    seek_req_t r;
    int gap;
    if ($urandom_range(99) < tx_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'b0, delta};
    s_axis_tuser <= {wr, hc};
    r.delta = delta; r.head_change = hc; r.is_write = wr;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(r);
    sent++;
    @(negedge clk);
  endtask

  // Called right after a negedge, so the valid drops before the next posedge.
  task drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_seek.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function logic signed [DELTA_W-1:0] pick_delta();
    int unsigned c3, m;
    c3 = (sb.cyl == 0) ? 0 : sb.cyl / 3;
    case ($urandom_range(5))
      0: m = $urandom_range(4);
      1: m = (c3 > 2) ? $urandom_range(c3 - 2, c3 + 2) : $urandom_range(5);
      2: m = $urandom_range((sb.cyl == 0) ? 1 : sb.cyl);
      3: return DELTA_W'($urandom);
      4: m = $urandom_range(65535, 65536);
      default: m = $urandom_range(65536);
    endcase
    if ($urandom_range(1)) return -DELTA_W'(m);
    return DELTA_W'(m);
  endfunction

  function logic [TIME_W-1:0] pick_time();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      2: return TIME_W'($urandom_range(1, 2000));
      3: return TIME_W'($urandom_range(1, 30000));
      default: return TIME_W'($urandom);
    endcase
  endfunction

  function logic [CYL_W-1:0] pick_cyl();
    case ($urandom_range(4))
      0: return CYL_W'($urandom_range(3));
      1: return CYL_W'($urandom_range(4, 100));
      2: return '1;
      default: return CYL_W'($urandom);
    endcase
  endfunction

  task directed_set();
    send_request(17'sd0, 1'b0, 1'b1);
    send_request(17'sd0, 1'b1, 1'b1);
    send_request(17'sd1, 1'b0, 1'b0);
    send_request(-17'sd1, 1'b1, 1'b0);
    send_request(17'sd33, 1'b0, 1'b1);
    send_request(17'sd34, 1'b1, 1'b1);
    send_request(17'sd65535, 1'b0, 1'b0);
    send_request(-17'sd65535, 1'b0, 1'b1);
    send_request(17'h10000, 1'b1, 1'b0);
  endtask

  initial begin
    int n;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: curve and line on 100 cylinders, then constant, none,
    // a zero cylinder count, saturation and a negative curve.
    set_all(MODE_CURVE, 16'd100, 18'd2000, 18'd8000, 18'd15000, 18'd500, 18'd3000);
    directed_set();
    drain();
    write_reg(REG_MODE, TIME_W'(MODE_LINE));
    directed_set();
    drain();
    set_all(MODE_CONST, 16'd0, 18'd10, 18'h3FFFF, 18'd0, 18'd100, 18'd100);
    send_request(17'sd5, 1'b1, 1'b1);
    drain();
    write_reg(REG_MODE, TIME_W'(MODE_NONE));
    send_request(17'sd5, 1'b1, 1'b1);
    drain();
    set_all(MODE_LINE, 16'd0, 18'd10, 18'd20, 18'd30, 18'd0, 18'd0);
    send_request(17'sd2, 1'b0, 1'b0);
    drain();
    set_all(MODE_CURVE, 16'd1, 18'd0, 18'd0, 18'h3FFFF, 18'h3FFFF, 18'd0);
    send_request(17'h10000, 1'b0, 1'b1);
    drain();
    set_all(MODE_CURVE, 16'd65535, 18'h3FFFF, 18'd0, 18'd0, 18'd0, 18'd0);
    send_request(17'sd65535, 1'b0, 1'b0);
    drain();

    // Random phases: each changes every register and the idle pattern.
    for (int ph = 0; ph < 12; ph++) begin
      set_all(($urandom_range(3) == 0) ? 2'($urandom_range(1)) : 2'($urandom_range(2, 3)),
              pick_cyl(), pick_time(), pick_time(), pick_time(), pick_time(), pick_time());
      case (ph % 4)
        0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_gap_pct = 80; rx_stall_pct = 0;  end
        2: begin tx_gap_pct = 0;  rx_stall_pct = 80; end
        default: begin tx_gap_pct = 32; rx_stall_pct = 32; end
      endcase
      // The pipeline fills and its input stalls while the receiver holds off.
      if (ph == 4) rx_hold = 300;
      n = 0;
      while (n < 135) begin
        send_request(pick_delta(), 1'($urandom), 1'($urandom));
        n++;
      end
      drain();
      tx_gap_pct = 0;
      rx_stall_pct = 0;
    end

    $display("Sent %0d seek requests over all four modes and twelve random settings,",
             sent);
    $display("with sender gaps, receiver stalls and a long hold-off; %0d results checked.",
             sb.checked);
    if (sb.errors == 0 && sb.expected_seek.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
hw/rtl/dstm_pkg.sv
hw/rtl/dstm_div.sv
hw/rtl/disk_seek_time_model_top.sv
tb/sv/disk_seek_time_model_top_test.sv
